FILE: design/itba_pkg.sv
package itba_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_WIDTH     = 6;
    localparam int DIGIT_WIDTH     = 6;
    localparam int CHAR_WIDTH      = 7;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NINE = 6'd9;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN  = 6'd10;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_DIV_START,
        ACT_STORE,
        ACT_SIGN,
        ACT_READ,
        ACT_DIGIT
    } act_t;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic more_digits;
        logic sign_wait;
        logic out_full;
        logic count_nz;
    } stat_t;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] c;
        if (d > DIGIT_NINE) begin
            c = CHAR_A + {1'b0, d - DIGIT_TEN};
        end else begin
            c = CHAR_ZERO + {1'b0, d};
        end
        return c;
    endfunction

endpackage

FILE: design/integer_to_base_ascii.sv
// Converts one signed VALUE_WIDTH-bit integer per request into its text in the
// configured base (2 to 36, reset 10, writes outside the range saturate), one
// ASCII character per result, most significant first, with a leading '-' for
// negative values and last_char set on the final character. A small microcode
// program steps a shared restoring divider that yields one quotient bit per
// cycle, once per digit, and the program waits while the output is stalled. A
// minus sign is sent from the step that always runs between the divisions and
// the digits. A new value is accepted only after every character of the last
// one has been issued. The radix may be written only while no item is in
// progress.
module integer_to_base_ascii
    import itba_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [RADIX_WIDTH-1:0]        cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CHAR_WIDTH-1:0]         m_character,
    output logic                          m_last_char
);

    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [RADIX_WIDTH-1:0] radix_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic                   neg_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W-1:0]       count_dec;
    logic [DIGIT_WIDTH-1:0] digit_mem [VALUE_WIDTH];
    logic [DIGIT_WIDTH-1:0] rd_reg;
    logic                   out_valid_reg;
    logic [CHAR_WIDTH-1:0]  out_char_reg;
    logic                   out_last_reg;
    logic                   out_free;
    logic                   div_start;
    logic                   div_busy;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [DIGIT_WIDTH-1:0] div_rem;
    stat_t                  stat;
    act_t                   act;

    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign div_start = act == ACT_DIV_START;

    assign stat.in_valid    = s_valid;
    assign stat.div_busy    = div_busy;
    assign stat.more_digits = (div_quot != '0) && (count_inc < CNT_FULL);
    assign stat.sign_wait   = neg_reg && !out_free;
    assign stat.out_full    = !out_free;
    assign stat.count_nz    = count_reg != '0;

    itba_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .act     (act)
    );

    itba_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (radix_reg),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid) begin
            if (cfg_data < RADIX_MIN) begin
                radix_reg <= RADIX_MIN;
            end else if (cfg_data > RADIX_MAX) begin
                radix_reg <= RADIX_MAX;
            end else begin
                radix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_reg   <= 1'b0;
            count_reg <= '0;
        end else begin
            case (act)
                ACT_ACCEPT: begin
                    if (s_valid) begin
                        neg_reg   <= s_value[VALUE_WIDTH-1];
                        count_reg <= '0;
                    end
                end
                ACT_STORE: begin
                    count_reg <= count_inc;
                end
                ACT_DIGIT: begin
                    if (out_free) begin
                        count_reg <= count_dec;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (act == ACT_ACCEPT && s_valid) begin
            mag_reg <= s_value[VALUE_WIDTH-1] ? ~s_value + 1'b1 : s_value;
        end else if (act == ACT_STORE) begin
            mag_reg <= div_quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (act == ACT_STORE) begin
            digit_mem[count_reg[IDX_W-1:0]] <= div_rem;
        end
        if (act == ACT_READ) begin
            rd_reg <= digit_mem[count_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((act == ACT_SIGN && neg_reg && out_free)
                     || (act == ACT_DIGIT && out_free)) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (act == ACT_SIGN && neg_reg && out_free) begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end else if (act == ACT_DIGIT && out_free) begin
            out_char_reg <= digit_char(rd_reg);
            out_last_reg <= count_reg == CNT_ONE;
        end
    end

    assign cfg_ready   = 1'b1;
    assign s_ready     = act == ACT_ACCEPT;
    assign m_valid     = out_valid_reg;
    assign m_character = out_char_reg;
    assign m_last_char = out_last_reg;

endmodule

FILE: design/itba_div.sv
module itba_div
    import itba_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_WIDTH-1:0] divisor,
    output logic                   busy,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [DIGIT_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    logic                   busy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [VALUE_WIDTH-1:0] q_reg;
    logic [DIGIT_WIDTH-1:0] rem_reg;
    logic [DIGIT_WIDTH:0]   rem_shift;
    logic [DIGIT_WIDTH:0]   rem_diff;
    logic                   q_bit;

    assign rem_shift = {rem_reg, q_reg[VALUE_WIDTH-1]};
    assign q_bit     = rem_shift >= {1'b0, divisor};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[VALUE_WIDTH-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[DIGIT_WIDTH-1:0] : rem_shift[DIGIT_WIDTH-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/itba_seq.sv
module itba_seq
    import itba_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output act_t  act
);

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_DIV_BUSY,
        COND_MORE_DIGITS,
        COND_SIGN_WAIT,
        COND_OUT_FULL,
        COND_COUNT_NZ
    } cond_t;

    localparam int PC_W = 3;

    typedef struct packed {
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    localparam logic [PC_W-1:0] PC_ACCEPT = 3'd0;
    localparam logic [PC_W-1:0] PC_START  = 3'd1;
    localparam logic [PC_W-1:0] PC_WAIT   = 3'd2;
    localparam logic [PC_W-1:0] PC_STORE  = 3'd3;
    localparam logic [PC_W-1:0] PC_SIGN   = 3'd4;
    localparam logic [PC_W-1:0] PC_READ   = 3'd5;
    localparam logic [PC_W-1:0] PC_DIGIT  = 3'd6;
    localparam logic [PC_W-1:0] PC_LOOP   = 3'd7;

    // The final step falls through to step zero when the step counter wraps.
    function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            PC_ACCEPT: w = '{ACT_ACCEPT,    COND_NO_INPUT,    PC_ACCEPT};
            PC_START:  w = '{ACT_DIV_START, COND_NEVER,       PC_ACCEPT};
            PC_WAIT:   w = '{ACT_NONE,      COND_DIV_BUSY,    PC_WAIT};
            PC_STORE:  w = '{ACT_STORE,     COND_MORE_DIGITS, PC_START};
            PC_SIGN:   w = '{ACT_SIGN,      COND_SIGN_WAIT,   PC_SIGN};
            PC_READ:   w = '{ACT_READ,      COND_NEVER,       PC_ACCEPT};
            PC_DIGIT:  w = '{ACT_DIGIT,     COND_OUT_FULL,    PC_DIGIT};
            PC_LOOP:   w = '{ACT_NONE,      COND_COUNT_NZ,    PC_READ};
            default:   w = '{ACT_NONE,      COND_NEVER,       PC_ACCEPT};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctrl_t           word;
    logic            taken;

    assign word = rom(pc_reg);

    always_comb begin
        case (word.cond)
            COND_NEVER:       taken = 1'b0;
            COND_NO_INPUT:    taken = !stat.in_valid;
            COND_DIV_BUSY:    taken = stat.div_busy;
            COND_MORE_DIGITS: taken = stat.more_digits;
            COND_SIGN_WAIT:   taken = stat.sign_wait;
            COND_OUT_FULL:    taken = stat.out_full;
            COND_COUNT_NZ:    taken = stat.count_nz;
            default:          taken = 1'b0;
        endcase
        pc_next = taken ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign act = word.act;

endmodule
